@@ design/twc_pkg.sv @@
// trie word counter package: pool sizes, widths, character codes and sequencer states
// used by the counter top level and its shared incrementer; no dependencies

package twc_pkg;

  // node pool and alphabet
  localparam int POOL_NODES    = 65536;
  localparam int ALPHABET_SIZE = 26;
  localparam int NODE_W        = 16;
  localparam int FREE_W        = NODE_W + 1;
  localparam int SLOT_W        = 5;
  localparam int COUNT_W       = 32;
  localparam int TAG_W         = NODE_W + SLOT_W;
  localparam int LINK_DEPTH    = POOL_NODES * ALPHABET_SIZE;
  localparam int LINK_AW       = $clog2(LINK_DEPTH);

  // character codes
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;

  // result status codes
  localparam logic STATUS_COUNTED = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [FREE_W-1:0]  free_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [TAG_W-1:0]   tag_t;
  typedef logic [LINK_AW-1:0] link_addr_t;

  // walk sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINK,
    ST_TAG,
    ST_COUNT,
    ST_OUT
  } state_t;

endpackage

@@ design/twc_ram.sv @@
// generic single write port, single read port ram with registered read data
// no dependencies

module twc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/twc_incr.sv @@
// shared saturating incrementer for word counts and the free node pointer
// depends on twc_pkg

module twc_incr (
  input  twc_pkg::count_t operand,
  output twc_pkg::count_t result
);
  import twc_pkg::*;

  // hold at all ones, otherwise add one
  always_comb begin
    if (operand == '1) begin
      result = operand;
    end else begin
      result = operand + COUNT_W'(1);
    end
  end

endmodule

@@ design/trie_word_counter.sv @@
// A live-word letter holds in_ready low in the link and tag states (link read, tag read, update);
// a delimiter ending a word passes the count state before its result loads, a dropped word does not.
// A byte is taken only in the idle state, after the dependent link and tag ram reads; a word end
// also waits while the previous result is still held in the output register.
// Reset (rst_n low, synchronous): walk at the root, free pointer at node one, no result held.
// The rams are not swept: only nodes below the free pointer are trusted and each child
// link is confirmed by its parent/letter tag, so no clearing pass is needed.

module trie_word_counter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_char_code,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [twc_pkg::NODE_W-1:0]  out_node_id,
  output logic [twc_pkg::COUNT_W-1:0] out_word_count,
  output logic                        out_word_status
);
  import twc_pkg::*;

  state_t     state_r, state_nxt;
  node_t      cur_r, cur_nxt;
  free_t      free_r, free_nxt;
  logic       drop_r, drop_nxt;
  slot_t      slot_r, slot_nxt;
  link_addr_t link_addr_r, link_addr_nxt;
  node_t      child_r, child_nxt;
  node_t      res_node_r, res_node_nxt;
  count_t     res_count_r, res_count_nxt;
  logic       res_status_r, res_status_nxt;
  logic       out_valid_r, out_valid_nxt;
  node_t      out_node_r, out_node_nxt;
  count_t     out_count_r, out_count_nxt;
  logic       out_status_r, out_status_nxt;

  logic       in_xfer;
  logic       is_lower, is_upper, is_letter;
  slot_t      in_slot;
  link_addr_t in_link_addr;
  logic       hit, pool_free, out_load;

  logic       link_we;
  node_t      link_rdata;
  logic       tag_we;
  tag_t       tag_rdata;
  logic       count_we;
  node_t      count_waddr;
  count_t     count_wdata, count_rdata;
  count_t     inc_operand, inc_result;

  // input transfer and letter folding
  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign is_lower  = (in_char_code >= CHAR_LOWER_A) && (in_char_code <= CHAR_LOWER_Z);
  assign is_upper  = (in_char_code >= CHAR_UPPER_A) && (in_char_code <= CHAR_UPPER_Z);
  assign is_letter = is_lower || is_upper;

  always_comb begin
    logic [7:0] diff;
    diff    = is_lower ? (in_char_code - CHAR_LOWER_A) : (in_char_code - CHAR_UPPER_A);
    in_slot = diff[SLOT_W-1:0];
  end

  // link ram row of the current node, one entry per letter
  assign in_link_addr = LINK_AW'(cur_r) * LINK_AW'(ALPHABET_SIZE) + LINK_AW'(in_slot);

  // a stored child counts only if allocated and tagged with this parent and letter
  assign hit       = (child_r != '0) && (FREE_W'(child_r) < free_r)
                     && (tag_rdata == {cur_r, slot_r});
  assign pool_free = (free_r < FREE_W'(POOL_NODES));
  assign out_load  = !out_valid_r || out_ready;

  // shared incrementer: free pointer while walking, node count at word end
  assign inc_operand = (state_r == ST_COUNT) ? count_rdata : COUNT_W'(free_r);

  twc_incr u_incr (
    .operand (inc_operand),
    .result  (inc_result)
  );

  // child links, node_count*26 entries
  twc_ram #(
    .WIDTH (NODE_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_addr_r),
    .wdata (free_r[NODE_W-1:0]),
    .raddr (in_link_addr),
    .rdata (link_rdata)
  );

  // parent node and letter of every allocated node
  twc_ram #(
    .WIDTH (TAG_W),
    .DEPTH (POOL_NODES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (free_r[NODE_W-1:0]),
    .wdata ({cur_r, slot_r}),
    .raddr (link_rdata),
    .rdata (tag_rdata)
  );

  // word counts, zeroed as each node is allocated
  twc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (POOL_NODES)
  ) u_count_ram (
    .clk   (clk),
    .we    (count_we),
    .waddr (count_waddr),
    .wdata (count_wdata),
    .raddr (cur_r),
    .rdata (count_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          priority if (is_letter) begin
            state_nxt = drop_r ? ST_IDLE : ST_LINK;
          end else if (drop_r) begin
            state_nxt = ST_OUT;
          end else if (cur_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_COUNT;
          end
        end
      end
      ST_LINK:  state_nxt = ST_TAG;
      ST_TAG:   state_nxt = ST_IDLE;
      ST_COUNT: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and ram controls
  always_comb begin
    cur_nxt        = cur_r;
    free_nxt       = free_r;
    drop_nxt       = drop_r;
    slot_nxt       = slot_r;
    link_addr_nxt  = link_addr_r;
    child_nxt      = child_r;
    res_node_nxt   = res_node_r;
    res_count_nxt  = res_count_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_node_nxt   = out_node_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    link_we        = 1'b0;
    tag_we         = 1'b0;
    count_we       = 1'b0;
    count_waddr    = cur_r;
    count_wdata    = inc_result;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          slot_nxt      = in_slot;
          link_addr_nxt = in_link_addr;
          if (!is_letter) begin
            if (drop_r) begin
              // dropped word closes with an overflow result
              drop_nxt       = 1'b0;
              cur_nxt        = '0;
              res_node_nxt   = '0;
              res_count_nxt  = '0;
              res_status_nxt = STATUS_DROPPED;
            end
          end
        end
      end
      ST_LINK: begin
        child_nxt = link_rdata;
      end
      ST_TAG: begin
        priority if (hit) begin
          cur_nxt = child_r;
        end else if (pool_free) begin
          // allocate a fresh node from the bump pointer
          link_we     = 1'b1;
          tag_we      = 1'b1;
          count_we    = 1'b1;
          count_waddr = free_r[NODE_W-1:0];
          count_wdata = '0;
          cur_nxt     = free_r[NODE_W-1:0];
          free_nxt    = inc_result[FREE_W-1:0];
        end else begin
          drop_nxt = 1'b1;
        end
      end
      ST_COUNT: begin
        // saturating count update at word end
        count_we       = 1'b1;
        res_node_nxt   = cur_r;
        res_count_nxt  = inc_result;
        res_status_nxt = STATUS_COUNTED;
        cur_nxt        = '0;
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_node_nxt   = res_node_r;
          out_count_nxt  = res_count_r;
          out_status_nxt = res_status_r;
        end
      end
      default: begin
        cur_nxt = cur_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      free_r      <= FREE_W'(1);
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      free_r      <= free_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    slot_r       <= slot_nxt;
    link_addr_r  <= link_addr_nxt;
    child_r      <= child_nxt;
    res_node_r   <= res_node_nxt;
    res_count_r  <= res_count_nxt;
    res_status_r <= res_status_nxt;
    out_node_r   <= out_node_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_node_id     = out_node_r;
  assign out_word_count  = out_count_r;
  assign out_word_status = out_status_r;

endmodule

@@ dv/testbench.sv @@
// self-checking testbench for trie_word_counter: byte stimulus, a trie word-count predictor
// and a result checker; depends on twc_pkg and the trie_word_counter top level
`timescale 1ns / 1ps

module testbench;
  import twc_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1500;
  localparam int AFTER_FULL_ITEMS = 300;
  localparam int LEX_WORDS = 40;
  localparam int LEX_MAX = 8;
  localparam int MAX_PRINTED = 100;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    node_t  node;
    count_t count;
    logic   status;
  } word_result_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          in_char_code;
  logic                out_valid;
  logic                out_ready;
  logic [NODE_W-1:0]   out_node_id;
  logic [COUNT_W-1:0]  out_word_count;
  logic                out_word_status;

  // trie model state
  node_t        link_table [int];
  count_t       word_tally [POOL_NODES];
  free_t        free_node;
  int           walk_node;
  bit           walk_dropped;
  word_result_t pending_words [$];

  // vocabulary of short words over a narrow alphabet, so prefixes are shared
  slot_t lex_slot [LEX_WORDS][LEX_MAX];
  int    lex_len  [LEX_WORDS];

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_hold_cycles = 0;
  int error_count = 0;
  int cycle_count = 0;

  trie_word_counter u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_char_code    (in_char_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_node_id     (out_node_id),
    .out_word_count  (out_word_count),
    .out_word_status (out_word_status)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench failed");
      $finish;
    end
  end

  task automatic report_error(input string what);
    if (error_count < MAX_PRINTED) $display("[%0t] error: %s", $realtime, what);
    error_count++;
  endtask

  function automatic bit is_letter(input logic [7:0] code);
    return (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) ||
           (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z);
  endfunction

  function automatic logic [7:0] rand_delimiter();
    logic [7:0] code;
    code = 8'($urandom_range(0, 255));
    while (is_letter(code)) code = 8'($urandom_range(0, 255));
    return code;
  endfunction

  task automatic clear_trie_model();
    link_table.delete();
    foreach (word_tally[i]) word_tally[i] = '0;
    free_node    = 1;
    walk_node    = 0;
    walk_dropped = 1'b0;
    pending_words.delete();
  endtask

  // advance the trie walk by one byte and queue the word result it causes
  task automatic tally_byte(input logic [7:0] code);
    int           slot;
    int           key;
    word_result_t res;
    if (is_letter(code)) begin
      slot = (code >= CHAR_LOWER_A) ? int'(code - CHAR_LOWER_A) : int'(code - CHAR_UPPER_A);
      if (walk_dropped) return;
      key = walk_node * ALPHABET_SIZE + slot;
      if (link_table.exists(key)) begin
        walk_node = link_table[key];
      end else if (free_node < POOL_NODES) begin
        link_table[key] = free_node[NODE_W-1:0];
        walk_node = free_node;
        free_node++;
      end else begin
        walk_dropped = 1'b1;
      end
    end else if (walk_dropped) begin
      walk_dropped = 1'b0;
      walk_node = 0;
      res.node   = '0;
      res.count  = '0;
      res.status = STATUS_DROPPED;
      pending_words = {pending_words, res};
    end else if (walk_node != 0) begin
      if (word_tally[walk_node] != '1) word_tally[walk_node]++;
      res.node   = walk_node[NODE_W-1:0];
      res.count  = word_tally[walk_node];
      res.status = STATUS_COUNTED;
      pending_words = {pending_words, res};
      walk_node = 0;
    end
  endtask

  // offer one byte, hold it until the transfer, then update the model
  task automatic send_char(input logic [7:0] code);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_char_code <= code;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tally_byte(code);
    @(negedge clk);
  endtask

  task automatic send_letter(input int slot);
    logic [7:0] base;
    base = $urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A;
    send_char(base + 8'(slot));
  endtask

  task automatic send_lex_word(input int idx);
    for (int i = 0; i < lex_len[idx]; i++) send_letter(lex_slot[idx][i]);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // receiver: random gap before each result, or a long hold when one is asked for
  initial begin : receiver
    int unsigned gap;
    out_ready = 1'b0;
    forever begin
      gap = rx_idle ? $urandom_range(0, 19) : 0;
      if (rx_hold_cycles != 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  // compare each result transfer with the oldest expected word
  always @(posedge clk) begin : word_checker
    word_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        report_error($sformatf("unexpected result node %0d count %0d status %0d",
                               out_node_id, out_word_count, out_word_status));
      end else begin
        want = pending_words.pop_front();
        if (out_node_id !== want.node)
          report_error($sformatf("node_id %0d, expected %0d", out_node_id, want.node));
        if (out_word_count !== want.count)
          report_error($sformatf("word_count %0d, expected %0d", out_word_count, want.count));
        if (out_word_status !== want.status)
          report_error($sformatf("word_status %0d, expected %0d",
                                 out_word_status, want.status));
      end
    end
  end

  // boundary bytes around both letter ranges, case folding, delimiters at the root
  task automatic test_directed();
    logic [7:0] seq [20];
    seq = '{CHAR_SPACE, 8'h00, 8'hff,
            CHAR_LOWER_A, CHAR_SPACE,
            CHAR_UPPER_A, 8'h00,
            CHAR_LOWER_Z, CHAR_UPPER_Z, 8'hff,
            CHAR_UPPER_Z, CHAR_UPPER_A - 8'd1,
            CHAR_LOWER_Z, CHAR_UPPER_Z + 8'd1,
            CHAR_LOWER_A, CHAR_LOWER_A - 8'd1,
            CHAR_UPPER_A, CHAR_LOWER_Z + 8'd1,
            8'h7f, 8'h80};
    foreach (seq[i]) send_char(seq[i]);
    drain_results();
  endtask

  // text made of vocabulary words, fresh words and noise, idling in blocks
  task automatic test_random_text();
    int sent;
    int pick;
    int len;
    int block;
    sent  = 0;
    block = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent / 200 != block) begin
        block   = sent / 200;
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        pick = $urandom_range(0, LEX_WORDS - 1);
        send_lex_word(pick);
        sent += lex_len[pick];
      end else if (pick < 92) begin
        len = $urandom_range(1, 10);
        repeat (len) send_letter($urandom_range(0, 25));
        sent += len;
      end else begin
        send_char(8'($urandom_range(0, 255)));
        sent++;
      end
      // one or a run of delimiters
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(2, 4) : 1) begin
        send_char(rand_delimiter());
        sent++;
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    drain_results();
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_output_backpressure();
    tx_idle = 1'b0;
    rx_hold_cycles = 400;
    repeat (40) begin
      send_lex_word($urandom_range(0, LEX_WORDS - 1));
      send_char(rand_delimiter());
    end
    tx_idle = 1'b1;
    drain_results();
  endtask

  // long fresh words until the node pool is used up, then a dropped word
  task automatic test_pool_exhaustion();
    int len;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    while (free_node < POOL_NODES) begin
      len = $urandom_range(200, 3000);
      for (int i = 0; i < len && free_node < POOL_NODES; i++) send_letter($urandom_range(0, 25));
      if (free_node < POOL_NODES) send_char(rand_delimiter());
    end
    // the walk sits on a fresh node, so the next letter finds the pool full
    repeat (3) send_letter($urandom_range(0, 25));
    send_char(rand_delimiter());
    send_char(CHAR_SPACE);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    drain_results();
  endtask

  // full pool: known words still count, new ones are dropped
  task automatic test_after_exhaustion();
    int sent;
    int len;
    sent = 0;
    while (sent < AFTER_FULL_ITEMS) begin
      if ($urandom_range(0, 1)) begin
        send_lex_word($urandom_range(0, LEX_WORDS - 1));
      end else begin
        len = $urandom_range(1, 10);
        repeat (len) send_letter($urandom_range(0, 25));
      end
      repeat ($urandom_range(1, 2)) begin
        send_char(rand_delimiter());
        sent++;
      end
    end
    drain_results();
  endtask

  // a word left open at the end of the stream gives nothing
  task automatic test_unfinished_word();
    send_lex_word($urandom_range(0, LEX_WORDS - 1));
    send_letter($urandom_range(0, 25));
    drain_results();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_char_code = '0;
    clear_trie_model();
    foreach (lex_len[w]) begin
      lex_len[w] = $urandom_range(1, LEX_MAX);
      foreach (lex_slot[w][i]) lex_slot[w][i] = slot_t'($urandom_range(0, 5));
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_text();
    test_output_backpressure();
    test_pool_exhaustion();
    test_after_exhaustion();
    test_unfinished_word();

    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
